/* src/wildcard_pattern_matcher_defines.svh */
// Assertion macros for the checker file of the wildcard pattern matcher.
`ifndef WILDCARD_PATTERN_MATCHER_DEFINES_SVH
`define WILDCARD_PATTERN_MATCHER_DEFINES_SVH

// Concurrent assertion that is switched off while reset is asserted.
`define WPM_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("wildcard pattern matcher: check failed");

// Concurrent assertion that is also checked while reset is asserted.
`define WPM_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("wildcard pattern matcher: check failed");

`endif

/* src/wpm_pkg.sv */
`default_nettype none
package wpm_pkg;

  localparam int MAX_PATTERN    = 64;
  localparam int POSITION_WIDTH = 24;
  localparam int SYM_WIDTH      = 5;
  localparam int PIDX_WIDTH     = 6;
  localparam int LEN_WIDTH      = 7;
  localparam int ACT_WIDTH      = 2;
  localparam int CELL_IDX_WIDTH = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

  localparam logic [SYM_WIDTH-1:0] SYM_WILD = '0;

  localparam logic [ACT_WIDTH-1:0] ACT_LOAD    = 2'd0;
  localparam logic [ACT_WIDTH-1:0] ACT_TEXT    = 2'd1;
  localparam logic [ACT_WIDTH-1:0] ACT_RESTART = 2'd2;

  typedef struct packed {
    logic [ACT_WIDTH-1:0]  action;
    logic [SYM_WIDTH-1:0]  symbol;
    logic [PIDX_WIDTH-1:0] pattern_index;
  } in_item_t;

  typedef struct packed {
    logic [POSITION_WIDTH-1:0] match_start;
    logic                      matched;
  } out_item_t;

  typedef struct packed {
    logic                 step;
    logic                 clear;
    logic [SYM_WIDTH-1:0] feed_sym;
    logic [SYM_WIDTH-1:0] load_sym;
  } cell_ctrl_t;

  typedef enum logic [1:0] {
    ST_RUN    = 2'b01,
    ST_REPLAY = 2'b10
  } state_e;

endpackage
`default_nettype wire

/* src/wpm_cell.sv */
`default_nettype none
module wpm_cell
  import wpm_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cell_ctrl_t           ctrl_i,
  input  logic                 load_i,
  input  logic [SYM_WIDTH-1:0] win_i,
  input  logic                 flag_i,
  output logic [SYM_WIDTH-1:0] win_o,
  output logic                 flag_o,
  output logic                 flag_next_o
);

  logic [SYM_WIDTH-1:0] pat_q;
  logic [SYM_WIDTH-1:0] win_q, win_d;
  logic                 flag_q, flag_d;
  logic                 sym_eq;

  // The flag says that the pattern prefix ending at this cell matches the
  // text that ends at the newest symbol.
  assign sym_eq = (pat_q == ctrl_i.feed_sym) || (pat_q == SYM_WILD) ||
                  (ctrl_i.feed_sym == SYM_WILD);

  assign flag_next_o = ctrl_i.step ? (flag_i & sym_eq) : flag_q;

  always_comb begin
    win_d  = win_q;
    flag_d = flag_q;
    if (ctrl_i.clear) begin
      win_d  = SYM_WILD;
      flag_d = 1'b1;
    end else if (ctrl_i.step) begin
      win_d  = win_i;
      flag_d = flag_i & sym_eq;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q  <= SYM_WILD;
      flag_q <= 1'b1;
    end else begin
      win_q  <= win_d;
      flag_q <= flag_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      pat_q <= ctrl_i.load_sym;
    end
  end

  assign win_o  = win_q;
  assign flag_o = flag_q;

endmodule
`default_nettype wire

/* src/wildcard_pattern_matcher.sv */
`default_nettype none
// An accepted text symbol gives a result, the window start and the match flag, once the text
// since the last restart is at least as long as the pattern; the result is registered and shown
// in the next cycle. Loads, restarts and unused actions give no result. A row of 64 cells holds
// the text window, the pattern and one running match flag per pattern prefix, all stepped
// together. After a pattern load not followed by a restart, the first following text symbol is
// stalled while the window is rotated once through the row to rebuild the flags against the new
// pattern; further text symbols then run at one per cycle while the output is not stalled.
module wildcard_pattern_matcher
  import wpm_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  in_item_t             in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output out_item_t            out_data_o,
  input  logic                 cfg_we_i,
  input  logic [LEN_WIDTH-1:0] cfg_data_i
);

  state_e                    state_q, state_d;
  logic                      dirty_q, dirty_d;
  logic [CELL_IDX_WIDTH-1:0] rep_cnt_q, rep_cnt_d;
  logic [LEN_WIDTH-1:0]      len_q;
  logic [POSITION_WIDTH-1:0] cnt_q, cnt_d;
  logic                      out_valid_q, out_valid_d;
  out_item_t                 out_q, out_d;

  logic                      in_acc, is_text, is_load, is_restart, is_replay;
  logic                      out_busy;
  logic [LEN_WIDTH-1:0]      len_eff;
  logic [CELL_IDX_WIDTH-1:0] sel_idx;
  cell_ctrl_t                ctrl;

  logic [SYM_WIDTH-1:0]      win   [MAX_PATTERN];
  logic [MAX_PATTERN-1:0]    flag;
  logic [MAX_PATTERN-1:0]    flag_next;
  logic [MAX_PATTERN-1:0]    load_en;

  assign is_replay  = (state_q == ST_REPLAY);
  assign out_busy   = out_valid_q & out_stall_i;
  assign in_stall_o = is_replay | out_busy |
                      (dirty_q & in_valid_i & (in_data_i.action == ACT_TEXT));
  assign in_acc     = in_valid_i & ~in_stall_o;
  assign is_text    = in_acc & (in_data_i.action == ACT_TEXT);
  assign is_load    = in_acc & (in_data_i.action == ACT_LOAD);
  assign is_restart = in_acc & (in_data_i.action == ACT_RESTART);

  always_comb begin
    if (len_q == '0) begin
      len_eff = LEN_WIDTH'(1);
    end else if (int'(len_q) > MAX_PATTERN) begin
      len_eff = LEN_WIDTH'(MAX_PATTERN);
    end else begin
      len_eff = len_q;
    end
  end

  assign sel_idx = CELL_IDX_WIDTH'(len_eff - LEN_WIDTH'(1));

  assign ctrl.step     = is_text | is_replay;
  assign ctrl.clear    = is_restart;
  assign ctrl.feed_sym = is_replay ? win[MAX_PATTERN-1] : in_data_i.symbol;
  assign ctrl.load_sym = in_data_i.symbol;

  for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
    logic [SYM_WIDTH-1:0] win_in;
    logic                 flag_in;

    if (j == 0) begin : g_head
      assign win_in  = ctrl.feed_sym;
      assign flag_in = 1'b1;
    end else begin : g_body
      assign win_in  = win[j-1];
      assign flag_in = flag[j-1];
    end

    assign load_en[j] = is_load && (int'(in_data_i.pattern_index) == j);

    wpm_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .load_i      (load_en[j]),
      .win_i       (win_in),
      .flag_i      (flag_in),
      .win_o       (win[j]),
      .flag_o      (flag[j]),
      .flag_next_o (flag_next[j])
    );
  end

  always_comb begin
    state_d   = state_q;
    dirty_d   = dirty_q;
    rep_cnt_d = rep_cnt_q;
    unique case (state_q)
      ST_RUN: begin
        if (in_valid_i && dirty_q && !out_busy && (in_data_i.action == ACT_TEXT)) begin
          state_d   = ST_REPLAY;
          rep_cnt_d = '0;
        end
      end
      ST_REPLAY: begin
        rep_cnt_d = rep_cnt_q + CELL_IDX_WIDTH'(1);
        if (rep_cnt_q == CELL_IDX_WIDTH'(MAX_PATTERN - 1)) begin
          state_d = ST_RUN;
          dirty_d = 1'b0;
        end
      end
      default: begin
        state_d = ST_RUN;
      end
    endcase
    if (is_load) begin
      dirty_d = 1'b1;
    end else if (is_restart) begin
      dirty_d = 1'b0;
    end
  end

  always_comb begin
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q & out_stall_i;
    out_d       = out_q;
    if (is_restart) begin
      cnt_d = '0;
    end else if (is_text) begin
      if (cnt_q != '1) begin
        cnt_d = cnt_q + POSITION_WIDTH'(1);
      end
      if (cnt_d >= POSITION_WIDTH'(len_eff)) begin
        out_valid_d       = 1'b1;
        out_d.match_start = cnt_d - POSITION_WIDTH'(len_eff) + POSITION_WIDTH'(1);
        out_d.matched     = flag_next[sel_idx];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_RUN;
      dirty_q     <= 1'b0;
      rep_cnt_q   <= '0;
      len_q       <= LEN_WIDTH'(1);
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      dirty_q     <= dirty_d;
      rep_cnt_q   <= rep_cnt_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        len_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

/* src/wpm_checker.sv */
`default_nettype none
`include "wildcard_pattern_matcher_defines.svh"
module wpm_checker
  import wpm_pkg::*;
(
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 in_valid_i,
  input wire logic                 in_stall_o,
  input wire in_item_t             in_data_i,
  input wire logic                 out_valid_o,
  input wire logic                 out_stall_i,
  input wire out_item_t            out_data_o,
  input wire logic                 cfg_we_i,
  input wire logic [LEN_WIDTH-1:0] cfg_data_i
);

  logic in_acc;
  logic text_acc;
  logic out_hold;
  logic cfg_seen;

  assign in_acc   = in_valid_i & ~in_stall_o;
  assign text_acc = in_acc & (in_data_i.action == ACT_TEXT);
  assign out_hold = out_valid_o & out_stall_i;
  assign cfg_seen = cfg_we_i & (cfg_data_i == cfg_data_i);

  `WPM_ASSERT_ALWAYS(a_reset_no_result, clk_i, !rst_ni |=> !out_valid_o)
  `WPM_ASSERT(a_result_from_text, clk_i, rst_ni, (out_valid_o && !$past(out_hold)) |-> $past(text_acc))
  `WPM_ASSERT(a_other_no_result, clk_i, rst_ni, (in_acc && !text_acc && !cfg_seen) |=> !out_valid_o)
  `WPM_ASSERT(a_start_nonzero, clk_i, rst_ni, out_valid_o |-> (out_data_o.match_start != '0))
  `WPM_ASSERT(a_out_hold, clk_i, rst_ni, out_hold |=> (out_valid_o && $stable(out_data_o)))

endmodule

bind wildcard_pattern_matcher wpm_checker u_wpm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o),
  .cfg_we_i    (cfg_we_i),
  .cfg_data_i  (cfg_data_i)
);
`default_nettype wire
